FILE: design/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// shared types, constants and rounding helpers for the quaternion to euler block
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int OPND_W  = 18;   // atan2 operand width, Q14
  localparam int SUM_W   = 36;   // exact Q28 sum width
  localparam int ISQ_STEPS = 15; // square root steps for a 29 bit radicand
  localparam int ATAN_LEN  = 24;

  localparam logic signed [SUM_W-1:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [14:0] HALF_PI_Q13 = 15'sd12868;

  localparam logic signed [31:0] ATAN_Q28 [ATAN_LEN] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

  // one queued item between the front and the back
  typedef struct packed {
    logic signed [OPND_W-1:0] roll_y;
    logic signed [OPND_W-1:0] roll_x;
    logic signed [OPND_W-1:0] yaw_y;
    logic signed [OPND_W-1:0] yaw_x;
    logic signed [15:0]       s;      // pitch sine, Q14
    logic [28:0]              n;      // 1 - s*s, Q28
    logic                     clamp;
    logic                     psign;
  } q2e_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q2e_qstat_t;

  // Q28 -> Q14, round half away from zero, no saturation
  function automatic logic signed [SUM_W:0] rnd_q14(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] r;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    r = (mag + SUM_W'(8192)) >> 14;
    return v[SUM_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  // Q28 sum -> saturated Q14 atan2 operand
  function automatic logic signed [OPND_W-1:0] to_opnd(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W:0] r;
    r = rnd_q14(v);
    if (r > 37'sd131071) begin
      return 18'sd131071;
    end else if (r < -37'sd131072) begin
      return -18'sd131072;
    end else begin
      return r[OPND_W-1:0];
    end
  endfunction

endpackage

FILE: design/quaternion_to_euler_zyx_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx_top
// unit quaternion (Q1.14) to ZYX euler angles (Q3.13 radians)
// ----------------------------------------------------------------------------
// Takes one quaternion per clock and gives one result per clock when the
// output side keeps up. From input transaction to result an item passes
// five front stages of products and operand rounding, the queue, fifteen
// square root stages for the pitch cosine, the unrolled cordic pipeline and
// the output register. The front and the back each stall on their own; the
// queue between them holds QUEUE_DEPTH items. Pitch is forced to +-pi/2 with
// pitch_clamped set when |2(wy - zx)| reaches one.
module quaternion_to_euler_zyx_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // qw[15:0], qx[31:16], qy[47:32], qz[63:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
  output logic        m_axis_tuser    // pitch_clamped[0]
);
  import q2e_pkg::*;

  logic       f_valid, push, pop;
  q2e_entry_t f_entry, q_entry;
  q2e_qstat_t qstat;
  logic signed [15:0] roll, yaw;
  logic signed [14:0] pitch;

  q2e_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .out_valid(f_valid), .out_ready(!qstat.full), .out_entry(f_entry)
  );

  assign push = f_valid && !qstat.full;

  q2e_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_entry(f_entry),
    .pop(pop), .pop_entry(q_entry), .stat(qstat)
  );

  q2e_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst),
    .in_avail(!qstat.empty), .in_entry(q_entry), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .roll(roll), .pitch(pitch), .yaw(yaw), .clamped(m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, yaw, pitch, roll};

  a_clamp_pitch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> pitch == HALF_PI_Q13 || pitch == -HALF_PI_Q13)
    else $error("clamped pitch is not +-pi/2");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> roll <= PI_Q13 && roll >= -PI_Q13 && yaw <= PI_Q13 && yaw >= -PI_Q13)
    else $error("angle outside +-pi");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

  a_full_stalls_front: assert property (@(posedge clk) disable iff (rst)
    qstat.full && f_valid |-> !s_axis_tready)
    else $error("front advanced into a full queue");

endmodule

FILE: design/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// accepts quaternions, forms products, sums and atan2 operands
// ----------------------------------------------------------------------------
module q2e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output q2e_pkg::q2e_entry_t out_entry
);
  import q2e_pkg::*;

  logic [4:0] vld;
  logic       en;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] pwx, pyz, pxx, pyy, pwy, pzx, pwz, pxy, pzz;
  logic signed [SUM_W-1:0] roll_ys, roll_xs, yaw_ys, yaw_xs, ps;
  logic signed [OPND_W-1:0] roll_y, roll_x, yaw_y, yaw_x;
  logic signed [15:0] s;
  logic clamp, psign;
  logic signed [SUM_W:0] s_full;
  logic signed [31:0] ss;

  assign en        = !vld[4] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  assign s_full = rnd_q14(ps);
  assign ss     = s * s;

  always_ff @(posedge clk) begin
    if (en) begin
      qw <= in_data[15:0];
      qx <= in_data[31:16];
      qy <= in_data[47:32];
      qz <= in_data[63:48];

      pwx <= qw * qx;
      pyz <= qy * qz;
      pxx <= qx * qx;
      pyy <= qy * qy;
      pwy <= qw * qy;
      pzx <= qz * qx;
      pwz <= qw * qz;
      pxy <= qx * qy;
      pzz <= qz * qz;

      roll_ys <= (SUM_W'(pwx) + SUM_W'(pyz)) <<< 1;
      roll_xs <= ONE_Q28 - ((SUM_W'(pxx) + SUM_W'(pyy)) <<< 1);
      yaw_ys  <= (SUM_W'(pwz) + SUM_W'(pxy)) <<< 1;
      yaw_xs  <= ONE_Q28 - ((SUM_W'(pyy) + SUM_W'(pzz)) <<< 1);
      ps      <= (SUM_W'(pwy) - SUM_W'(pzx)) <<< 1;

      roll_y <= to_opnd(roll_ys);
      roll_x <= to_opnd(roll_xs);
      yaw_y  <= to_opnd(yaw_ys);
      yaw_x  <= to_opnd(yaw_xs);
      s      <= s_full[15:0];
      clamp  <= (ps >= ONE_Q28) || (ps <= -ONE_Q28);
      psign  <= ps[SUM_W-1];

      out_entry.roll_y <= roll_y;
      out_entry.roll_x <= roll_x;
      out_entry.yaw_y  <= yaw_y;
      out_entry.yaw_x  <= yaw_x;
      out_entry.s      <= s;
      // garbage when clamped, the back ignores it then
      out_entry.n      <= 29'(ONE_Q28[31:0] - ss);
      out_entry.clamp  <= clamp;
      out_entry.psign  <= psign;
    end
  end

endmodule

FILE: design/q2e_fifo.sv
// ----------------------------------------------------------------------------
// q2e_fifo
// short queue that decouples the front from the back
// ----------------------------------------------------------------------------
module q2e_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  q2e_pkg::q2e_entry_t push_entry,
  input  logic                pop,
  output q2e_pkg::q2e_entry_t pop_entry,
  output q2e_pkg::q2e_qstat_t stat
);
  import q2e_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q2e_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: design/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic, atan2(y, x) in Q13 radians saturated to +-pi
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [q2e_pkg::OPND_W-1:0]   x_in,
  input  logic signed [q2e_pkg::OPND_W-1:0]   y_in,
  output logic signed [15:0]                  angle
);
  import q2e_pkg::*;

  localparam int W = OPND_W + 3;

  logic signed [W-1:0] xs [STEPS+1];
  logic signed [W-1:0] ys [STEPS+1];
  logic signed [31:0]  zs [STEPS+1];
  logic                zf [STEPS+1];

  logic signed [W-1:0] xe, ye;
  logic signed [31:0]  zfin;
  logic [31:0]         zmag;
  logic [31:0]         zr;
  logic signed [32:0]  zq;

  assign xe = W'(x_in);
  assign ye = W'(y_in);

  // move a left half plane vector into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (xe[W-1]) begin
        if (!ye[W-1]) begin
          xs[0] <= ye;
          ys[0] <= -xe;
          zs[0] <= HALF_PI_Q28;
        end else begin
          xs[0] <= -ye;
          ys[0] <= xe;
          zs[0] <= -HALF_PI_Q28;
        end
      end else begin
        xs[0] <= xe;
        ys[0] <= ye;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!ys[i][W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_Q28[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_Q28[i];
        end
      end
    end
  end

  // Q28 -> Q13, round half away from zero, then limit to +-pi
  assign zfin = zs[STEPS];
  assign zmag = zfin[31] ? 32'(-zfin) : 32'(zfin);
  assign zr   = (zmag + 32'd16384) >> 15;
  assign zq   = zfin[31] ? -$signed({1'b0, zr}) : $signed({1'b0, zr});

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf[STEPS]) begin
        angle <= '0;
      end else if (zq > 33'(PI_Q13)) begin
        angle <= PI_Q13;
      end else if (zq < -33'(PI_Q13)) begin
        angle <= -PI_Q13;
      end else begin
        angle <= zq[15:0];
      end
    end
  end

endmodule

FILE: design/q2e_back.sv
// ----------------------------------------------------------------------------
// q2e_back
// square root for the pitch cosine, three cordics and the output register
// ----------------------------------------------------------------------------
module q2e_back #(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_avail,
  input  q2e_pkg::q2e_entry_t in_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  roll,
  output logic signed [14:0]  pitch,
  output logic signed [15:0]  yaw,
  output logic                clamped
);
  import q2e_pkg::*;

  localparam int CL = STEPS + 2;        // cordic latency
  localparam int L  = ISQ_STEPS + CL;

  logic         en;
  logic [L-1:0] vld;

  logic [29:0]  nq [ISQ_STEPS];
  logic [29:0]  rq [ISQ_STEPS];
  q2e_entry_t   eq [ISQ_STEPS];

  logic [CL-1:0] clamp_d, psign_d;

  logic signed [OPND_W-1:0] pc_x, pc_y;
  logic signed [15:0] roll_a, pitch_a, yaw_a;

  assign en  = !out_valid || out_ready;
  assign pop = en && in_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[L-2:0], pop};
      out_valid <= vld[L-1];
    end
  end

  // digit by digit square root, one step per stage
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
    localparam logic [29:0] BIT = 30'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic [29:0] n_in, r_in;
    q2e_entry_t  e_in;
    if (k == 0) begin : g_first
      assign n_in = 30'(in_entry.n);
      assign r_in = '0;
      assign e_in = in_entry;
    end else begin : g_next
      assign n_in = nq[k-1];
      assign r_in = rq[k-1];
      assign e_in = eq[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        eq[k] <= e_in;
        if (n_in >= r_in + BIT) begin
          nq[k] <= n_in - (r_in + BIT);
          rq[k] <= (r_in >> 1) + BIT;
        end else begin
          nq[k] <= n_in;
          rq[k] <= r_in >> 1;
        end
      end
    end
  end

  assign pc_x = OPND_W'(rq[ISQ_STEPS-1][14:0]);
  assign pc_y = OPND_W'(eq[ISQ_STEPS-1].s);

  q2e_cordic #(.STEPS(STEPS)) u_roll (
    .clk(clk), .en(en),
    .x_in(eq[ISQ_STEPS-1].roll_x), .y_in(eq[ISQ_STEPS-1].roll_y), .angle(roll_a)
  );

  q2e_cordic #(.STEPS(STEPS)) u_pitch (
    .clk(clk), .en(en), .x_in(pc_x), .y_in(pc_y), .angle(pitch_a)
  );

  q2e_cordic #(.STEPS(STEPS)) u_yaw (
    .clk(clk), .en(en),
    .x_in(eq[ISQ_STEPS-1].yaw_x), .y_in(eq[ISQ_STEPS-1].yaw_y), .angle(yaw_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_d <= {clamp_d[CL-2:0], eq[ISQ_STEPS-1].clamp};
      psign_d <= {psign_d[CL-2:0], eq[ISQ_STEPS-1].psign};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll    <= roll_a;
      yaw     <= yaw_a;
      clamped <= clamp_d[CL-1];
      if (clamp_d[CL-1]) begin
        pitch <= psign_d[CL-1] ? -HALF_PI_Q13 : HALF_PI_Q13;
      end else if (pitch_a > 16'(HALF_PI_Q13)) begin
        pitch <= HALF_PI_Q13;
      end else if (pitch_a < -16'(HALF_PI_Q13)) begin
        pitch <= -HALF_PI_Q13;
      end else begin
        pitch <= pitch_a[14:0];
      end
    end
  end

endmodule
